/* sv/bst_pkg.sv */
// Types and constants for the brightest spot tracker.
// No dependencies; imported by brightest_spot_tracker.
package bst_pkg;

    localparam int DIM_W      = 15;
    localparam int ROW_W      = 12;
    localparam int COORD_W    = 13;
    localparam int SUM_OUT_W  = 11;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_HEIGHT = 4096;
    localparam int OUT_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // First member sits in the highest bits of a packed struct.
    typedef struct packed {
        logic [COORD_W-1:0]   offset_y;
        logic [COORD_W-1:0]   offset_x;
        logic [SUM_OUT_W-1:0] peak_sum;
        logic [COORD_W-1:0]   peak_y;
        logic [COORD_W-1:0]   peak_x;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

/* sv/brightest_spot_tracker.sv */
// Brightest 2x2 spot tracker: top level.
// Depends on bst_pkg; holds the previous-row memory and the compare pipeline.
//
// Takes one gray pixel per clock in raster order and, on the last pixel of each
// frame, emits one word with the position of the largest 2x2 window sum, that
// sum, and the offset from the frame center. Throughput is one pixel per cycle,
// set by the single-port read-first row memory that is read and written at the
// pixel's column in the same cycle. The last pixel's flag passes through the
// r_last1 and r_last2 registers before the result word is loaded into an
// output register, where it waits; the input stalls only while a finished
// result is held and the next one is due. Frames with width or height below 3
// report -1 for position and sum. The row memory needs no clearing after reset.
module brightest_spot_tracker
    import bst_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                 i_cfg_index,
    input  logic [CFG_W-1:0]                     i_cfg_wdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // gray_pixel
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // peak_x, peak_y, peak_sum, offset_x, offset_y, zero pad
    output logic [OUT_DATA_W-1:0]                o_m_axis_tdata
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SUM_W  = PIXEL_BITS + 2;

    logic [CFG_W-1:0]      r_frame_width;
    logic [CFG_W-1:0]      r_frame_height;
    logic [DIM_W-1:0]      w_dim;
    logic [DIM_W-1:0]      h_dim;

    logic [PIXEL_BITS-1:0] r_row_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_up;

    logic [ADDR_W-1:0]     r_col;
    logic [ROW_W-1:0]      r_row;
    logic [DIM_W-1:0]      col_x;
    logic [DIM_W-1:0]      row_x;
    logic                  accept;
    logic                  advance;
    logic                  win0;
    logic                  end_row0;
    logic                  last0;
    logic [PIXEL_BITS-1:0] pix0;

    logic                  r_v1;
    logic [PIXEL_BITS-1:0] r_pix1;
    logic [ADDR_W-1:0]     r_col1;
    logic [ROW_W-1:0]      r_row1;
    logic                  r_win1;
    logic                  r_last1;
    logic [PIXEL_BITS-1:0] r_left_cur;
    logic [PIXEL_BITS-1:0] r_left_prev;

    logic                  r_v2;
    logic [SUM_W-1:0]      r_sum2;
    logic [ADDR_W-1:0]     r_col2;
    logic [ROW_W-1:0]      r_row2;
    logic                  r_win2;
    logic                  r_last2;

    logic                  r_best_found;
    logic [SUM_W-1:0]      r_best_sum;
    logic [ADDR_W-1:0]     r_best_col;
    logic [ROW_W-1:0]      r_best_row;
    logic                  n_best_found;
    logic [SUM_W-1:0]      n_best_sum;
    logic [ADDR_W-1:0]     n_best_col;
    logic [ROW_W-1:0]      n_best_row;
    logic                  take;

    logic                  r_out_valid;
    t_result               r_result;
    t_result               n_result;

    // Clamp the frame size registers to the supported range.
    always_comb begin
        if (r_frame_width == '0) begin
            w_dim = DIM_W'(1);
        end else if (DIM_W'(r_frame_width) > DIM_W'(MAX_WIDTH)) begin
            w_dim = DIM_W'(MAX_WIDTH);
        end else begin
            w_dim = DIM_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_dim = DIM_W'(1);
        end else if (DIM_W'(r_frame_height) > DIM_W'(MAX_HEIGHT)) begin
            h_dim = DIM_W'(MAX_HEIGHT);
        end else begin
            h_dim = DIM_W'(r_frame_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hold the pipeline only when a new result word is due and the old one still waits.
    assign advance         = !(r_out_valid && !i_m_axis_tready && r_v2 && r_last2);
    assign o_s_axis_tready = advance;
    assign accept          = i_s_axis_tvalid && advance;
    assign pix0            = i_s_axis_tdata[PIXEL_BITS-1:0];

    assign col_x    = DIM_W'(r_col);
    assign row_x    = DIM_W'(r_row);
    assign win0     = (col_x >= DIM_W'(1)) && (row_x >= DIM_W'(1))
                   && (col_x + DIM_W'(2) <= w_dim) && (row_x + DIM_W'(2) <= h_dim);
    assign end_row0 = (col_x + DIM_W'(1) >= w_dim);
    assign last0    = end_row0 && (row_x + DIM_W'(1) >= h_dim);

    // Read-first row memory: the old pixel above comes out as the new one goes in.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row_mem[r_col] <= pix0;
            r_up             <= r_row_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (end_row0) begin
                r_col <= '0;
                r_row <= last0 ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix1  <= pix0;
            r_col1  <= r_col;
            r_row1  <= r_row;
            r_win1  <= win0;
            r_last1 <= last0;
        end
        if (advance && r_v1) begin
            r_sum2  <= SUM_W'(r_left_prev) + SUM_W'(r_up)
                     + SUM_W'(r_left_cur) + SUM_W'(r_pix1);
            r_col2  <= r_col1;
            r_row2  <= r_row1;
            r_win2  <= r_win1;
            r_last2 <= r_last1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_left_cur  <= '0;
            r_left_prev <= '0;
        end else if (advance) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            if (r_v1) begin
                r_left_cur  <= r_pix1;
                r_left_prev <= r_up;
            end
        end
    end

    // Keep the largest sum; on a tie keep the smaller column.
    always_comb begin
        take = r_v2 && r_win2
            && (!r_best_found || (r_sum2 > r_best_sum)
                || ((r_sum2 == r_best_sum) && (r_col2 < r_best_col)));
        n_best_found = r_best_found || take;
        n_best_sum   = take ? r_sum2 : r_best_sum;
        n_best_col   = take ? r_col2 : r_best_col;
        n_best_row   = take ? r_row2 : r_best_row;

        if (n_best_found) begin
            n_result.peak_x   = COORD_W'(n_best_col);
            n_result.peak_y   = COORD_W'(n_best_row);
            n_result.peak_sum = SUM_OUT_W'(n_best_sum);
        end else begin
            n_result.peak_x   = '1;
            n_result.peak_y   = '1;
            n_result.peak_sum = '1;
        end
        n_result.offset_x = n_result.peak_x - COORD_W'(w_dim >> 1);
        n_result.offset_y = n_result.peak_y - COORD_W'(h_dim >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= 1'b0;
        end else if (advance && r_v2) begin
            r_best_found <= r_last2 ? 1'b0 : n_best_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_v2) begin
            r_best_sum <= n_best_sum;
            r_best_col <= n_best_col;
            r_best_row <= n_best_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_v2 && r_last2) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_v2 && r_last2) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - RESULT_W)'(0), r_result};

endmodule

/* verif/brightest_spot_monitor.sv */
// Monitor for the brightest spot tracker: mirrors the register writes, predicts one
// peak word per frame from the accepted pixels and compares the result stream.
// Depends on bst_pkg; instantiated beside the block by brightest_spot_tracker_tb.
module brightest_spot_monitor
    import bst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_ready,
    input  logic [7:0]            i_pix_data,
    input  logic                  i_peak_valid,
    input  logic                  i_peak_ready,
    input  logic [OUT_DATA_W-1:0] i_peak_data,
    output int                    o_mismatches,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS = 4096;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [7:0]       row_mem [MAX_COLS];
    logic [7:0]       left_pix;
    logic [7:0]       left_up;
    int               col_cnt;
    int               row_cnt;
    int               best_sum;
    int               best_col;
    int               best_row;
    int               mismatches;
    t_result          expected_peaks [$];

    function automatic int eff_dim(input logic [CFG_W-1:0] value, input int limit);
        if (value == '0) return 1;
        if (int'(value) > limit) return limit;
        return int'(value);
    endfunction

    task automatic clear_peak();
        best_sum = -1;
        best_col = -1;
        best_row = -1;
    endtask

    task automatic track_pixel(input logic [7:0] pix);
        int         cols;
        int         rows;
        int         sum;
        logic [7:0] up;
        t_result    peak;
        cols = eff_dim(width_reg, MAX_COLS);
        rows = eff_dim(height_reg, MAX_HEIGHT);
        up   = row_mem[col_cnt % MAX_COLS];
        if (col_cnt >= 1 && row_cnt >= 1 && col_cnt + 2 <= cols && row_cnt + 2 <= rows) begin
            sum = int'(left_up) + int'(up) + int'(left_pix) + int'(pix);
            // ties keep the leftmost column; rows tie by arrival order
            if (sum > best_sum || (sum == best_sum && col_cnt < best_col)) begin
                best_sum = sum;
                best_col = col_cnt;
                best_row = row_cnt;
            end
        end
        row_mem[col_cnt % MAX_COLS] = pix;
        left_up  = up;
        left_pix = pix;
        if (col_cnt + 1 >= cols) begin
            col_cnt = 0;
            if (row_cnt + 1 >= rows) begin
                peak.peak_x   = COORD_W'(best_col);
                peak.peak_y   = COORD_W'(best_row);
                peak.peak_sum = SUM_OUT_W'(best_sum);
                peak.offset_x = COORD_W'(best_col - cols / 2);
                peak.offset_y = COORD_W'(best_row - rows / 2);
                expected_peaks.push_back(peak);
                row_cnt = 0;
                clear_peak();
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
    endtask

    task automatic compare_field(input string name, input logic signed [15:0] want,
                                 input logic signed [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            left_pix   = '0;
            left_up    = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            foreach (row_mem[i]) row_mem[i] = '0;
            clear_peak();
            expected_peaks.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  width_reg  = i_cfg_wdata;
                    CFG_FRAME_HEIGHT: height_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) begin
                track_pixel(i_pix_data);
            end
            if (i_peak_valid && i_peak_ready) begin
                got = t_result'(i_peak_data[RESULT_W-1:0]);
                if (expected_peaks.size() == 0) begin
                    $display("%0t: result word expected none, got %h", $time, i_peak_data);
                    mismatches++;
                end else begin
                    want = expected_peaks.pop_front();
                    compare_field("peak_x", $signed(want.peak_x), $signed(got.peak_x));
                    compare_field("peak_y", $signed(want.peak_y), $signed(got.peak_y));
                    compare_field("peak_sum", $signed(want.peak_sum), $signed(got.peak_sum));
                    compare_field("offset_x", $signed(want.offset_x), $signed(got.offset_x));
                    compare_field("offset_y", $signed(want.offset_y), $signed(got.offset_y));
                    if (i_peak_data[OUT_DATA_W-1:RESULT_W] !== '0) begin
                        $display("%0t: pad bits expected 0, got %b", $time,
                                 i_peak_data[OUT_DATA_W-1:RESULT_W]);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_peaks.size();
    end

endmodule

/* verif/brightest_spot_tracker_tb.sv */
// Testbench top for the brightest spot tracker: resets the block, programs frame
// sizes and streams gray frames through it with random stalls on both sides.
// Depends on bst_pkg, brightest_spot_tracker and brightest_spot_monitor.
module brightest_spot_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bst_pkg::*;

    typedef enum {FILL_NOISE, FILL_FLAT, FILL_SPOT, FILL_BINARY} fill_e;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]      cfg_wdata  = '0;
    logic                  pix_valid  = 1'b0;
    logic                  pix_ready;
    logic [7:0]            pix_data   = '0;
    logic                  peak_valid;
    logic                  peak_ready = 1'b0;
    logic [OUT_DATA_W-1:0] peak_data;
    int                    mismatches;
    int                    pending;
    bit                    idle_on    = 1'b1;
    bit                    long_hold  = 1'b0;
    int                    pix_sent   = 0;

    always #5 clk = ~clk;

    brightest_spot_tracker dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (pix_valid),
        .o_s_axis_tready (pix_ready),
        .i_s_axis_tdata  (pix_data),
        .o_m_axis_tvalid (peak_valid),
        .i_m_axis_tready (peak_ready),
        .o_m_axis_tdata  (peak_data)
    );

    brightest_spot_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_pix_valid  (pix_valid),
        .i_pix_ready  (pix_ready),
        .i_pix_data   (pix_data),
        .i_peak_valid (peak_valid),
        .i_peak_ready (peak_ready),
        .i_peak_data  (peak_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    task automatic send_pixel(input logic [7:0] value);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= value;
        do @(posedge clk); while (!pix_ready);
        pix_sent++;
    endtask

    task automatic send_frame(input int cols, input int rows, input fill_e fill,
                              input logic [7:0] level, input int spot_col, input int spot_row);
        logic [7:0] value;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                case (fill)
                    FILL_NOISE:  value = 8'($urandom_range(0, 255));
                    FILL_FLAT:   value = level;
                    FILL_SPOT:   value = (c == spot_col && r == spot_row) ? 8'hFF : level;
                    FILL_BINARY: value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default:     value = level;
                endcase
                send_pixel(value);
            end
        end
    endtask

    // hold input, wait for every pending word, then let the pipeline drain
    task automatic settle();
        pix_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : peak_sink
        int hold;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                long_hold = 1'b0;
                peak_ready <= 1'b0;
                repeat (399) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                peak_ready <= 1'b0;
                hold = $urandom_range(1, 10);
                repeat (hold - 1) @(posedge clk);
            end else begin
                peak_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #20ms;
        $display("[brightest_spot_tracker] ERROR");
        $finish;
    end

    initial begin : stimulus
        int    base;
        int    phase;
        int    pick;
        int    w_val;
        int    h_val;
        int    cols;
        int    rows;
        fill_e fill;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // height stays at its reset value for the first frame
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        send_frame(1, 480, FILL_NOISE, 8'd0, 0, 0);
        settle();
        // fill the row memory past every width used below
        write_reg(CFG_FRAME_WIDTH, 13'd64);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        send_frame(64, 1, FILL_NOISE, 8'd0, 0, 0);
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd12);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        send_frame(12, 3, FILL_SPOT, 8'd200, 10, 1);
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd8);
        send_frame(3, 8, FILL_SPOT, 8'd0, 1, 6);
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        send_frame(1, 1, FILL_NOISE, 8'd0, 0, 0);
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        send_frame(2, 2, FILL_NOISE, 8'd0, 0, 0);
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        send_frame(3, 3, FILL_FLAT, 8'hFF, 0, 0);
        send_frame(3, 3, FILL_FLAT, 8'h00, 0, 0);
        send_frame(3, 3, FILL_NOISE, 8'h00, 0, 0);
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd4);
        write_reg(CFG_FRAME_HEIGHT, 13'd4);
        send_frame(4, 4, FILL_FLAT, 8'd100, 0, 0);
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd5);
        send_frame(5, 4, FILL_BINARY, 8'd0, 0, 0);
        send_frame(5, 4, FILL_SPOT, 8'd30, 4, 3);

        base  = pix_sent;
        phase = 0;
        while (pix_sent - base < 1300) begin
            idle_on = (pix_sent - base) < 1040;
            pick = $urandom_range(0, 9);
            if (phase == 2) begin
                w_val = 3;
                h_val = 3;
            end else if (pick == 0) begin
                w_val = $urandom_range(0, 2);
                h_val = $urandom_range(0, 8);
            end else if (pick == 1) begin
                w_val = $urandom_range(3, 10);
                h_val = $urandom_range(0, 2);
            end else if (pick == 2) begin
                w_val = $urandom_range(3, 40);
                h_val = $urandom_range(3, 12);
            end else begin
                w_val = $urandom_range(3, 10);
                h_val = $urandom_range(3, 6);
            end
            settle();
            write_reg(CFG_FRAME_WIDTH, CFG_W'(w_val));
            write_reg(CFG_FRAME_HEIGHT, CFG_W'(h_val));
            cols = (w_val == 0) ? 1 : w_val;
            rows = (h_val == 0) ? 1 : h_val;
            if (phase == 2) begin
                // stall the result side while frames keep coming
                long_hold = 1'b1;
                repeat (40) send_frame(cols, rows, FILL_NOISE, 8'd0, 0, 0);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    fill = fill_e'($urandom_range(0, 3));
                    send_frame(cols, rows, fill, 8'($urandom_range(0, 60)),
                               $urandom_range(0, cols - 1), $urandom_range(0, rows - 1));
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                // resize while a frame is under way
                repeat ($urandom_range(1, 2 * cols)) send_pixel(8'($urandom_range(0, 255)));
                settle();
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(CFG_FRAME_WIDTH, CFG_W'($urandom_range(0, 12)));
                end else begin
                    write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 12)));
                end
            end
            phase++;
        end

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("[brightest_spot_tracker] OK");
        end else begin
            $display("[brightest_spot_tracker] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/bst_pkg.sv
sv/brightest_spot_tracker.sv
verif/brightest_spot_monitor.sv
verif/brightest_spot_tracker_tb.sv
